### hdl/sird_pkg.sv
package sird_pkg;

  localparam int VALUE_BITS     = 32;
  localparam int MAX_SYMBOLS    = 32;
  localparam int SYM_BITS       = 8;
  localparam int ALPHA_WORDS    = 4;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int LEN_BITS       = 6;
  localparam int DIGIT_BITS     = $clog2(MAX_SYMBOLS);
  localparam int CHUNK_BITS     = 8;
  localparam int CHUNKS         = VALUE_BITS / CHUNK_BITS;
  localparam int STEP_BITS      = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int STACK_BITS     = $clog2(VALUE_BITS + 1);

  localparam logic [SYM_BITS-1:0] MINUS_SIGN = 8'h2D;
  localparam logic [SYM_BITS-1:0] PLUS_SIGN  = 8'h2B;
  localparam logic [LEN_BITS-1:0] MIN_RADIX  = LEN_BITS'(2);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BASE_LENGTH = 3'd0,
    REG_ALPHABET_0  = 3'd1,
    REG_ALPHABET_1  = 3'd2,
    REG_ALPHABET_2  = 3'd3,
    REG_ALPHABET_3  = 3'd4
  } reg_index_t;

  typedef logic [MAX_SYMBOLS-1:0][SYM_BITS-1:0] sym_array_t;

  typedef struct packed {
    logic ok;
    logic busy;
  } alpha_status_t;

  typedef struct packed {
    logic                  negative;
    logic [VALUE_BITS-1:0] mag;
  } job_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_SIGN,
    B_EMIT
  } back_state_t;

endpackage

### hdl/sird_cfg.sv
module sird_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sird_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [sird_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic [sird_pkg::LEN_BITS-1:0]        base_length,
  output sird_pkg::sym_array_t                 symbols,
  output sird_pkg::alpha_status_t              status
);
  import sird_pkg::*;

  logic [ALPHA_WORDS-1:0][CFG_DATA_BITS-1:0] alphabet;
  logic                  chk_busy;
  logic                  alpha_ok;
  logic [DIGIT_BITS-1:0] chk_idx;
  logic [SYM_BITS-1:0]   cur;
  logic                  len_ok;
  logic                  in_use;
  logic                  dup;
  logic                  sym_bad;

  assign cfg_ready = 1'b1;
  assign symbols   = sym_array_t'(alphabet);
  assign status.ok   = alpha_ok & ~chk_busy;
  assign status.busy = chk_busy;

  assign len_ok = (base_length >= MIN_RADIX) && (base_length <= LEN_BITS'(MAX_SYMBOLS));
  assign cur    = symbols[chk_idx];
  assign in_use = LEN_BITS'(chk_idx) < base_length;

  // compare the current symbol with every later symbol in use
  always_comb begin
    dup = 1'b0;
    for (int j = 0; j < MAX_SYMBOLS; j++) begin
      if ((DIGIT_BITS'(j) > chk_idx) && (LEN_BITS'(j) < base_length) &&
          (symbols[j] == cur)) begin
        dup = 1'b1;
      end
    end
  end

  assign sym_bad = in_use && ((cur == PLUS_SIGN) || (cur == MINUS_SIGN) || dup);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length <= '0;
      alphabet    <= '0;
      chk_busy    <= 1'b0;
      alpha_ok    <= 1'b0;
      chk_idx     <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_LENGTH: base_length <= cfg_data[LEN_BITS-1:0];
        REG_ALPHABET_0:  alphabet[0] <= cfg_data;
        REG_ALPHABET_1:  alphabet[1] <= cfg_data;
        REG_ALPHABET_2:  alphabet[2] <= cfg_data;
        REG_ALPHABET_3:  alphabet[3] <= cfg_data;
        default: ;
      endcase
      // any write restarts the sweep over the symbols
      chk_busy <= 1'b1;
      alpha_ok <= 1'b1;
      chk_idx  <= '0;
    end else if (chk_busy) begin
      if (!len_ok || sym_bad) begin
        alpha_ok <= 1'b0;
      end
      chk_idx <= chk_idx + 1'b1;
      if (chk_idx == DIGIT_BITS'(MAX_SYMBOLS - 1)) begin
        chk_busy <= 1'b0;
      end
    end
  end

endmodule

### hdl/sird_front.sv
module sird_front (
  input  logic                              push,
  output logic                              full,
  input  logic signed [sird_pkg::VALUE_BITS-1:0] value,
  input  sird_pkg::alpha_status_t           status,
  input  logic                              q_full,
  output logic                              q_push,
  output sird_pkg::job_t                    q_job
);
  import sird_pkg::*;

  logic [VALUE_BITS-1:0] raw;
  logic                  accept;

  assign full   = status.busy | q_full;
  assign accept = push & ~full;
  // words taken under a bad alphabet are dropped here
  assign q_push = accept & status.ok;

  assign raw            = VALUE_BITS'(value);
  assign q_job.negative = raw[VALUE_BITS-1];
  // unsigned magnitude; the most negative value comes out as the sign bit alone
  assign q_job.mag      = raw[VALUE_BITS-1] ? VALUE_BITS'(~raw + 1'b1) : raw;

endmodule

### hdl/sird_queue.sv
module sird_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  sird_pkg::job_t wr_job,
  output logic           q_full,
  input  logic           rd,
  output sird_pkg::job_t rd_job,
  output logic           q_empty
);
  import sird_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (wr && !q_full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd && !q_empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({wr && !q_full, rd && !q_empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/sird_back.sv
module sird_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           job_empty,
  input  sird_pkg::job_t                 job,
  output logic                           job_pop,
  input  logic [sird_pkg::LEN_BITS-1:0]  radix,
  input  sird_pkg::sym_array_t           symbols,
  output logic                           empty,
  input  logic                           pop,
  output logic [sird_pkg::SYM_BITS-1:0]  character,
  output logic                           last
);
  import sird_pkg::*;

  back_state_t           state;
  back_state_t           state_next;
  logic [VALUE_BITS-1:0] quo;
  logic [DIGIT_BITS-1:0] rem;
  logic [STEP_BITS-1:0]  step;
  logic                  negative;
  logic [DIGIT_BITS-1:0] stack [VALUE_BITS];
  logic [STACK_BITS-1:0] sp;
  logic [STACK_BITS-1:0] sp_m1;

  logic [VALUE_BITS-1:0] div_quo;
  logic [DIGIT_BITS-1:0] div_rem;
  logic                  last_chunk;

  // two-word result buffer
  logic [SYM_BITS-1:0]   ob_char [2];
  logic                  ob_last [2];
  logic                  ob_wr;
  logic                  ob_rd;
  logic [1:0]            ob_cnt;
  logic                  ob_full;
  logic                  ob_push;
  logic                  ob_pop;
  logic [SYM_BITS-1:0]   ob_in_char;
  logic                  ob_in_last;

  assign ob_full    = (ob_cnt == 2'd2);
  assign empty      = (ob_cnt == 2'd0);
  assign ob_pop     = pop & ~empty;
  assign character  = ob_char[ob_rd];
  assign last       = ob_last[ob_rd];
  assign last_chunk = (step == STEP_BITS'(CHUNKS - 1));
  assign sp_m1      = sp - 1'b1;

  // restoring division, one byte of the dividend per cycle
  always_comb begin
    logic [LEN_BITS-1:0]   r;
    logic [VALUE_BITS-1:0] q;
    r = {1'b0, rem};
    q = quo;
    for (int k = 0; k < CHUNK_BITS; k++) begin
      r = {r[LEN_BITS-2:0], q[VALUE_BITS-1]};
      q = {q[VALUE_BITS-2:0], 1'b0};
      if (r >= radix) begin
        r    = r - radix;
        q[0] = 1'b1;
      end
    end
    div_quo = q;
    div_rem = r[DIGIT_BITS-1:0];
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!job_empty) begin
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (last_chunk && (div_quo == '0)) begin
          state_next = negative ? B_SIGN : B_EMIT;
        end
      end
      B_SIGN: begin
        if (!ob_full) begin
          state_next = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!ob_full && (sp == STACK_BITS'(1))) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop    = 1'b0;
    ob_push    = 1'b0;
    ob_in_char = MINUS_SIGN;
    ob_in_last = 1'b0;
    case (state)
      B_IDLE: job_pop = ~job_empty;
      B_SIGN: ob_push = ~ob_full;
      B_EMIT: begin
        ob_push    = ~ob_full;
        ob_in_char = symbols[stack[sp_m1[DIGIT_BITS-1:0]]];
        ob_in_last = (sp == STACK_BITS'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_pop) begin
          quo      <= job.mag;
          negative <= job.negative;
          rem      <= '0;
          step     <= '0;
          sp       <= '0;
        end
      end
      B_DIV: begin
        quo <= div_quo;
        if (last_chunk) begin
          // digits stack up least significant first
          stack[sp[DIGIT_BITS-1:0]] <= div_rem;
          sp   <= sp + 1'b1;
          rem  <= '0;
          step <= '0;
        end else begin
          rem  <= div_rem;
          step <= step + 1'b1;
        end
      end
      B_EMIT: begin
        if (!ob_full) begin
          sp <= sp_m1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_char[ob_wr] <= ob_in_char;
      ob_last[ob_wr] <= ob_in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wr  <= 1'b0;
      ob_rd  <= 1'b0;
      ob_cnt <= '0;
    end else begin
      if (ob_push) begin
        ob_wr <= ~ob_wr;
      end
      if (ob_pop) begin
        ob_rd <= ~ob_rd;
      end
      case ({ob_push, ob_pop})
        2'b10:   ob_cnt <= ob_cnt + 1'b1;
        2'b01:   ob_cnt <= ob_cnt - 1'b1;
        default: ob_cnt <= ob_cnt;
      endcase
    end
  end

endmodule

### hdl/signed_integer_to_radix_digits_core.sv
// channel   signals                                 word
// input     push, full, value                       one signed 32-bit number
// result    empty, pop, character, last             one text byte, last on final byte
// config    cfg_valid, cfg_ready, cfg_index, cfg_data   one register write
//
// A number leaves the queue; the divider then works out its digits least
// significant first, taking the dividend one byte a cycle; a minus sign comes
// next if it is negative, then the digits most significant first. Emission
// waits while the two-word result buffer is full. A two-entry queue parts
// intake from the divider. After any config write full stays high while the
// alphabet is checked symbol by symbol; out of reset the alphabet counts as
// bad, and numbers taken under a bad alphabet give no bytes.
module signed_integer_to_radix_digits_core (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     push,
  output logic                                     full,
  input  logic signed [sird_pkg::VALUE_BITS-1:0]   value,
  output logic                                     empty,
  input  logic                                     pop,
  output logic [sird_pkg::SYM_BITS-1:0]            character,
  output logic                                     last,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [sird_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [sird_pkg::CFG_DATA_BITS-1:0]       cfg_data
);
  import sird_pkg::*;

  logic [LEN_BITS-1:0] base_length;
  sym_array_t          symbols;
  alpha_status_t       status;
  logic                q_full;
  logic                q_empty;
  logic                q_push;
  logic                q_pop;
  job_t                q_job;
  job_t                head_job;

  sird_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .base_length(base_length),
    .symbols    (symbols),
    .status     (status)
  );

  sird_front u_front (
    .push  (push),
    .full  (full),
    .value (value),
    .status(status),
    .q_full(q_full),
    .q_push(q_push),
    .q_job (q_job)
  );

  sird_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_push),
    .wr_job (q_job),
    .q_full (q_full),
    .rd     (q_pop),
    .rd_job (head_job),
    .q_empty(q_empty)
  );

  sird_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_empty(q_empty),
    .job      (head_job),
    .job_pop  (q_pop),
    .radix    (base_length),
    .symbols  (symbols),
    .empty    (empty),
    .pop      (pop),
    .character(character),
    .last     (last)
  );

endmodule
